@@ src/adfsm_pkg.sv @@
// Package with the item types, command codes and phase codes of the activity detector.
`default_nettype none

package adfsm_pkg;

    // Fixed field widths of the configuration registers and the items.
    localparam int unsigned TICK_W    = 16;
    localparam int unsigned BURST_W   = 7;
    localparam int unsigned THRESH_W  = 16;
    localparam int unsigned MAG_W     = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;

    // Number of quiet bursts in a row that halts the block.
    localparam logic [1:0] QUIET_LIMIT = 2'd3;

    // Command carried by an input item.
    typedef enum logic [1:0] {
        REQ_STEP   = 2'd0,
        REQ_RESUME = 2'd1,
        REQ_HALT   = 2'd2,
        REQ_ACK    = 2'd3
    } req_t;

    // Phase of the detector, also reported in each result item.
    typedef enum logic [2:0] {
        PH_HALTED   = 3'd0,
        PH_WAIT     = 3'd1,
        PH_SAMPLE   = 3'd2,
        PH_FILTER   = 3'd3,
        PH_DETECTED = 3'd4,
        PH_AWAIT    = 3'd5
    } phase_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAIT_TICKS   = 2'd0,
        CFG_BURST_LENGTH = 2'd1,
        CFG_THRESHOLD    = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_idx_t;

    // Input item.
    typedef struct packed {
        req_t               req_type;
        logic [MAG_W-1:0]   magnitude;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic       stopped_now;
        logic       activity_flag;
        logic       is_halted;
        logic [2:0] phase_code;
    } out_item_t;

endpackage

`default_nettype wire

@@ src/activity_detector_fsm_unit.sv @@
// Top level of the command-driven activity detector with input and result registers.
`default_nettype none

// Activity detector driven by command items. Every accepted item yields exactly one
// result item. The block takes one item per clock cycle while the result side does not
// stall: an input register holds the item, the phase machine and the running sum update
// in one pass of logic (one add, one 16 by 7 bit multiply and one compare), and a result
// register holds the answer, which is offered once the item has passed through the
// input register and the result register. Input and result sides are decoupled by
// these two registers; s_ready drops only when both are full and the result is not
// being taken. Configuration writes are always accepted (cfg_ready is tied high) and
// take effect for the next item that reaches the phase machine.
module activity_detector_fsm_unit #(
    parameter int unsigned MAX_BURST = 64,
    parameter int unsigned MAG_BITS  = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Input items.
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire adfsm_pkg::in_item_t                 s_item,
    // Result items.
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output adfsm_pkg::out_item_t                     m_item,
    // Configuration writes.
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [adfsm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [adfsm_pkg::CFG_DAT_W-1:0]     cfg_data
);

    // Derived widths.
    localparam int unsigned MAG_USE = (MAG_BITS < adfsm_pkg::MAG_W) ? MAG_BITS
                                                                     : adfsm_pkg::MAG_W;
    localparam int unsigned CNT_W   = $clog2(MAX_BURST + 1);
    localparam int unsigned SUM_W   = MAG_USE + $clog2(MAX_BURST);
    localparam int unsigned PROD_W  = adfsm_pkg::THRESH_W + CNT_W;
    localparam int unsigned CMP_W   = (SUM_W > PROD_W) ? SUM_W : PROD_W;
    localparam logic [adfsm_pkg::MAG_W-1:0] MAG_MASK =
        adfsm_pkg::MAG_W'((64'd1 << MAG_USE) - 64'd1);
    localparam logic [31:0] MAX_BURST_V = 32'(MAX_BURST);

    // Configuration registers.
    logic [adfsm_pkg::TICK_W-1:0]   wait_ticks_reg;
    logic [adfsm_pkg::BURST_W-1:0]  burst_length_reg;
    logic [adfsm_pkg::THRESH_W-1:0] threshold_reg;

    // Detector state.
    adfsm_pkg::phase_t              phase_reg, phase_next;
    logic [adfsm_pkg::TICK_W-1:0]   tick_count_reg, tick_count_next;
    logic [CNT_W-1:0]               sample_count_reg, sample_count_next;
    logic [SUM_W-1:0]               sample_sum_reg, sample_sum_next;
    logic [1:0]                     quiet_bursts_reg, quiet_bursts_next;
    logic                           detected_reg, detected_next;
    logic                           stopped;

    // Pipeline registers.
    logic                           in_valid_reg;
    adfsm_pkg::in_item_t            in_item_reg;
    logic                           m_valid_reg;
    adfsm_pkg::out_item_t           m_item_reg;

    // Handshake control.
    logic                           advance;
    logic                           step_en;

    // Working values.
    logic [31:0]                    burst_ext;
    logic [CNT_W-1:0]               eff_burst;
    logic [CNT_W-1:0]               count_inc;
    logic [SUM_W-1:0]               mag_used;
    logic [CMP_W-1:0]               limit;
    logic                           above;
    logic [1:0]                     quiet_inc;

    assign advance   = !m_valid_reg || m_ready;
    assign step_en   = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;
    assign cfg_ready = 1'b1;

    // Configuration register writes; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wait_ticks_reg   <= adfsm_pkg::TICK_W'(1);
            burst_length_reg <= adfsm_pkg::BURST_W'(1);
            threshold_reg    <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (adfsm_pkg::cfg_idx_t'(cfg_index))
                adfsm_pkg::CFG_WAIT_TICKS:   wait_ticks_reg   <= cfg_data;
                adfsm_pkg::CFG_BURST_LENGTH:
                    burst_length_reg <= cfg_data[adfsm_pkg::BURST_W-1:0];
                adfsm_pkg::CFG_THRESHOLD:    threshold_reg    <= cfg_data;
                adfsm_pkg::CFG_UNUSED:       ;
                default:                     ;
            endcase
        end
    end

    // Effective burst length: zero counts as one, and it is capped at MAX_BURST.
    always_comb begin
        burst_ext = 32'(burst_length_reg);
        if (burst_ext == 32'd0) begin
            eff_burst = CNT_W'(1);
        end else if (burst_ext > MAX_BURST_V) begin
            eff_burst = CNT_W'(MAX_BURST_V);
        end else begin
            eff_burst = CNT_W'(burst_ext);
        end
    end

    // Sample path values and the average test as sum > threshold * length.
    assign mag_used  = SUM_W'(in_item_reg.magnitude & MAG_MASK);
    assign count_inc = (sample_count_reg < eff_burst) ? CNT_W'(sample_count_reg + 1'b1)
                                                       : sample_count_reg;
    assign limit     = CMP_W'(threshold_reg) * CMP_W'(eff_burst);
    assign above     = CMP_W'(sample_sum_reg) > limit;
    assign quiet_inc = quiet_bursts_reg + 2'd1;

    // Next state of the phase machine for the item in the input register.
    always_comb begin
        phase_next        = phase_reg;
        tick_count_next   = tick_count_reg;
        sample_count_next = sample_count_reg;
        sample_sum_next   = sample_sum_reg;
        quiet_bursts_next = quiet_bursts_reg;
        detected_next     = detected_reg;
        stopped           = 1'b0;
        if (step_en) begin
            unique case (in_item_reg.req_type)
                adfsm_pkg::REQ_STEP: begin
                    unique case (phase_reg)
                        adfsm_pkg::PH_HALTED: ;
                        adfsm_pkg::PH_WAIT: begin
                            tick_count_next   = tick_count_reg + 1'b1;
                            sample_count_next = '0;
                            sample_sum_next   = '0;
                            if (tick_count_next == wait_ticks_reg) begin
                                phase_next = adfsm_pkg::PH_SAMPLE;
                            end
                        end
                        adfsm_pkg::PH_SAMPLE: begin
                            tick_count_next   = '0;
                            sample_sum_next   = sample_sum_reg + mag_used;
                            sample_count_next = count_inc;
                            if (count_inc >= eff_burst) begin
                                phase_next = adfsm_pkg::PH_FILTER;
                            end
                        end
                        adfsm_pkg::PH_FILTER: begin
                            if (above) begin
                                phase_next = adfsm_pkg::PH_DETECTED;
                            end else if (quiet_inc == adfsm_pkg::QUIET_LIMIT) begin
                                // Third quiet burst in a row halts the block.
                                phase_next        = adfsm_pkg::PH_HALTED;
                                quiet_bursts_next = '0;
                                stopped           = 1'b1;
                            end else begin
                                phase_next        = adfsm_pkg::PH_WAIT;
                                quiet_bursts_next = quiet_inc;
                            end
                        end
                        adfsm_pkg::PH_DETECTED: begin
                            detected_next     = 1'b1;
                            quiet_bursts_next = '0;
                            phase_next        = adfsm_pkg::PH_AWAIT;
                        end
                        adfsm_pkg::PH_AWAIT: begin
                            if (!detected_reg) begin
                                phase_next = adfsm_pkg::PH_WAIT;
                            end
                        end
                        default: ;
                    endcase
                end
                adfsm_pkg::REQ_RESUME: phase_next    = adfsm_pkg::PH_WAIT;
                adfsm_pkg::REQ_HALT:   phase_next    = adfsm_pkg::PH_HALTED;
                adfsm_pkg::REQ_ACK:    detected_next = 1'b0;
                default: ;
            endcase
        end
    end

    // Phase machine state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= adfsm_pkg::PH_HALTED;
            tick_count_reg   <= '0;
            sample_count_reg <= '0;
            sample_sum_reg   <= '0;
            quiet_bursts_reg <= '0;
            detected_reg     <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            tick_count_reg   <= tick_count_next;
            sample_count_reg <= sample_count_next;
            sample_sum_reg   <= sample_sum_next;
            quiet_bursts_reg <= quiet_bursts_next;
            detected_reg     <= detected_next;
        end
    end

    // Input register: holds one item until the phase machine takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    // Result register: loaded with the outcome of each item as it is processed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            m_item_reg.stopped_now   <= stopped;
            m_item_reg.activity_flag <= detected_next;
            m_item_reg.is_halted     <= (phase_next == adfsm_pkg::PH_HALTED);
            m_item_reg.phase_code    <= 3'(phase_next);
        end
    end

endmodule

`default_nettype wire
